// File: design/ual_pkg.sv
// shared types and constants for the unique append list
package ual_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // command queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // result field width for the entry total
  localparam int TOTAL_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DUMP_FWD = 2'd1,
    OP_DUMP_REV = 2'd2,
    OP_SIZE     = 2'd3
  } ual_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } ual_status_t;

  // classified command kinds seen by the back end
  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_SIZE,
    CMD_DUMP
  } ual_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } ual_bk_state_t;

  typedef struct packed {
    ual_op_t            opcode;
    logic signed [31:0] value;
  } ual_in_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [TOTAL_W-1:0] entry_total;
    ual_status_t        status;
    logic               last;
  } ual_out_t;

  typedef struct packed {
    ual_kind_t          kind;
    logic               reverse;
    logic signed [31:0] value;
  } ual_cmd_t;

endpackage

// File: design/unique_append_list.sv
// Top level of the unique append list: front end, command queue and back end.
//
// Input channel: an item (opcode, value) is taken at a rising edge where start
// is high and busy is low. busy rises only while the two-entry command queue
// is full. Opcodes: insert, forward dump, reverse dump, size query.
// Result channel: out_strobe marks a one-cycle result on out_result; the
// receiver has no way to hold it off, so results are never stalled.
// An insert or size query gives its single result from the result register
// once its command leaves the queue. Inserts and size queries sustain one item
// per cycle while no dump holds the back end; the duplicate search compares
// the value with all held entries in parallel. A dump occupies the back end
// for a start step, then one entry a cycle from the store, with last set on the
// final one. A dump of an empty list gives one result with the empty status.
// Reset (rst_n low, synchronous) empties the list and the queue and clears
// out_strobe; stored values are not cleared, only entries below the count
// are ever read.
module unique_append_list import ual_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ual_in_t  in_item,
  output logic     out_strobe,
  output ual_out_t out_result
);

  logic     q_valid;
  logic     q_pop;
  ual_cmd_t q_cmd;

  // acceptance and classification
  ual_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // execution
  ual_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

// File: design/ual_front.sv
// front end: item acceptance, opcode classification and command queue
module ual_front import ual_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ual_in_t  in_item,
  output logic     q_valid,
  output ual_cmd_t q_cmd,
  input  logic     q_pop
);

  ual_cmd_t           slot_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               q_full;
  logic               push;
  logic               pop;
  ual_cmd_t           cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.value   = in_item.value;
    cmd_in.reverse = 1'b0;
    unique case (in_item.opcode)
      OP_INSERT:   cmd_in.kind = CMD_INSERT;
      OP_DUMP_FWD: cmd_in.kind = CMD_DUMP;
      OP_DUMP_REV: begin
        cmd_in.kind    = CMD_DUMP;
        cmd_in.reverse = 1'b1;
      end
      OP_SIZE:     cmd_in.kind = CMD_SIZE;
      default:     cmd_in.kind = CMD_SIZE;
    endcase
  end

  // queue control
  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign busy    = q_full;
  assign push    = start && !q_full;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_IDX_W'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue slots hold payload only
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: design/ual_back.sv
// back end: entry store, duplicate search, append and dump sequencing
module ual_back import ual_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  ual_cmd_t q_cmd,
  output logic     q_pop,
  output logic     out_strobe,
  output ual_out_t out_result
);

  logic signed [31:0] entry_r [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  ual_bk_state_t      state_r, state_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic               rev_r, rev_nxt;
  logic               strobe_r, strobe_nxt;
  ual_out_t           result_r, result_nxt;
  logic [DEPTH-1:0]   match;
  logic               dup;
  logic               store_full;
  logic               wr_en;

  // parallel compare against every held entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (entry_r[i] == q_cmd.value) && (CNT_W'(i) < count_r);
    end
  end

  assign dup        = |match;
  assign store_full = (count_r == CNT_W'(DEPTH));

  // command execution and dump sequencing
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    rev_nxt    = rev_r;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    strobe_nxt = 1'b0;
    result_nxt.item_value  = '0;
    result_nxt.entry_total = TOTAL_W'(count_r);
    result_nxt.status      = ST_OK;
    result_nxt.last        = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_INSERT: begin
              strobe_nxt = 1'b1;
              priority if (dup) begin
                result_nxt.status = ST_DUP;
              end else if (store_full) begin
                result_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                result_nxt.entry_total = TOTAL_W'(count_r + CNT_W'(1));
              end
            end
            CMD_SIZE: begin
              strobe_nxt = 1'b1;
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                strobe_nxt        = 1'b1;
                result_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = BK_DUMP;
                rev_nxt   = q_cmd.reverse;
                rem_nxt   = IDX_W'(count_r - CNT_W'(1));
                ptr_nxt   = q_cmd.reverse ? IDX_W'(count_r - CNT_W'(1)) : '0;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      BK_DUMP: begin
        strobe_nxt            = 1'b1;
        result_nxt.item_value = entry_r[ptr_r];
        result_nxt.last       = (rem_r == '0);
        ptr_nxt = rev_r ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
        rem_nxt = rem_r - IDX_W'(1);
        if (rem_r == '0) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    rev_r    <= rev_nxt;
    result_r <= result_nxt;
    if (wr_en) begin
      entry_r[count_r[IDX_W-1:0]] <= q_cmd.value;
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule

// File: design/ual_checker.sv
// port-level checks for the unique append list, bound to the top level
module ual_checker import ual_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_strobe,
  input ual_out_t out_result
);

  // reset leaves the block quiet and ready
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("strobe or busy after reset");

  // rejects and empty reports are always single results
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.status != ST_OK |-> out_result.last)
    else $error("non-ok result without last");

  // an empty report carries no entry and no count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.status == ST_EMPTY |->
      out_result.entry_total == '0 && out_result.item_value == '0)
    else $error("empty report with data");

  // a dump runs back to back with a steady count
  a_dump_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result.last |=>
      out_strobe && $stable(out_result.entry_total) && out_result.status == ST_OK)
    else $error("dump burst broken");

endmodule

bind unique_append_list ual_checker u_ual_checker (.*);

// File: dv/tb.sv
// self-checking testbench for the unique append list: directed table, then random commands
module tb;
  import ual_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS = 500;

  // one row of the directed table; a typed row carries its expected single result
  typedef struct {
    ual_op_t            op;
    logic signed [31:0] val;
    bit                 typed;
    logic [TOTAL_W-1:0] total;
    ual_status_t        status;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ual_in_t  in_item;
  logic     out_strobe;
  ual_out_t out_result;

  // shadow copy of the list
  logic signed [31:0] shadow_store [DEPTH];
  int                 shadow_count;

  ual_out_t pending_results [$];
  dir_row_t dir_rows [$];
  int       items_taken;
  int       fail_count;
  bit       cur_typed;
  ual_out_t cur_typed_result;

  unique_append_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predict the results of one accepted item and update the shadow list
  function automatic void list_step(ual_in_t it);
    ual_out_t r;
    bit       dup;
    int       idx;
    r = '0;
    r.last = 1'b1;
    case (it.opcode)
      OP_INSERT: begin
        dup = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_store[i] == it.value) dup = 1'b1;
        end
        if (dup) begin
          r.status = ST_DUP;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[shadow_count] = it.value;
          shadow_count++;
          r.status = ST_OK;
        end
        r.entry_total = shadow_count[TOTAL_W-1:0];
        pending_results.push_back(r);
      end
      OP_SIZE: begin
        r.status = ST_OK;
        r.entry_total = shadow_count[TOTAL_W-1:0];
        pending_results.push_back(r);
      end
      default: begin
        r.entry_total = shadow_count[TOTAL_W-1:0];
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            idx = (it.opcode == OP_DUMP_FWD) ? i : shadow_count - 1 - i;
            r.item_value = shadow_store[idx];
            r.status = ST_OK;
            r.last = (i == shadow_count - 1);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // check results and take items at the rising edge
  always @(posedge clk) begin
    ual_out_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: item_value %0d status %0d", out_result.item_value,
                 out_result.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_result.item_value !== want.item_value) begin
            $error("item_value: expected %0d, got %0d", want.item_value,
                   out_result.item_value);
            fail_count++;
          end
          if (out_result.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total,
                   out_result.entry_total);
            fail_count++;
          end
          if (out_result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_result.status);
            fail_count++;
          end
          if (out_result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_result.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        items_taken++;
        list_step(in_item);
        // typed rows replace the predicted single result
        if (cur_typed) pending_results[pending_results.size() - 1] = cur_typed_result;
      end
    end
  end

  // present one item at a falling edge and hold it until taken
  task automatic send_item(input ual_op_t op, input logic signed [31:0] val,
                           input bit allow_idle);
    int      gap;
    int      target;
    ual_in_t it;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    it.opcode = op;
    it.value = val;
    target = items_taken + 1;
    start <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (items_taken < target);
  endtask

  // wait at a falling edge until every expected result has come
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic dir_row_t row(ual_op_t op, logic signed [31:0] val, bit typed,
                                   logic [TOTAL_W-1:0] total, ual_status_t status);
    dir_row_t d;
    d.op = op;
    d.val = val;
    d.typed = typed;
    d.total = total;
    d.status = status;
    return d;
  endfunction

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    ual_op_t            op;
    logic signed [31:0] val;
    bit                 allow_idle;
    int                 pick;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    items_taken = 0;
    fail_count = 0;
    shadow_count = 0;
    cur_typed = 1'b0;
    cur_typed_result = '0;
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;

    // empty list, then the value extremes, a duplicate and both dumps
    dir_rows.push_back(row(OP_SIZE, 32'hA5A5_A5A5, 1, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_DUMP_FWD, 32'h5A5A_5A5A, 1, 5'd0, ST_EMPTY));
    dir_rows.push_back(row(OP_DUMP_REV, 32'hFFFF_FFFF, 1, 5'd0, ST_EMPTY));
    dir_rows.push_back(row(OP_INSERT, 32'h8000_0000, 1, 5'd1, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h7FFF_FFFF, 1, 5'd2, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h8000_0000, 1, 5'd2, ST_DUP));
    dir_rows.push_back(row(OP_INSERT, 32'h0000_0000, 1, 5'd3, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hFFFF_FFFF, 1, 5'd4, ST_OK));
    dir_rows.push_back(row(OP_DUMP_FWD, 32'h0, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_DUMP_REV, 32'h0, 0, 5'd0, ST_OK));
    // fill the store
    dir_rows.push_back(row(OP_INSERT, 32'h0000_0001, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h1234_5678, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hDEAD_BEEF, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h5555_5555, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hAAAA_AAAA, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h0000_FFFF, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hFFFF_0000, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h7FFF_FFFE, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h8000_0001, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hFFFF_FFFE, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'h0000_0100, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_INSERT, 32'hC0FF_EE00, 0, 5'd0, ST_OK));
    // new value into a full store, then a duplicate while full, both dumps and a size query
    dir_rows.push_back(row(OP_INSERT, 32'h0000_0002, 1, 5'd16, ST_FULL));
    dir_rows.push_back(row(OP_INSERT, 32'hDEAD_BEEF, 1, 5'd16, ST_DUP));
    dir_rows.push_back(row(OP_DUMP_FWD, 32'h0, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_DUMP_REV, 32'h0, 0, 5'd0, ST_OK));
    dir_rows.push_back(row(OP_SIZE, 32'h0, 1, 5'd16, ST_OK));

    // reset
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_rows[k]) begin
      cur_typed = dir_rows[k].typed;
      cur_typed_result = '0;
      cur_typed_result.entry_total = dir_rows[k].total;
      cur_typed_result.status = dir_rows[k].status;
      cur_typed_result.last = 1'b1;
      send_item(dir_rows[k].op, dir_rows[k].val, 1'b1);
    end
    cur_typed = 1'b0;

    // hold off until the list has gone quiet
    start <= 1'b0;
    drain_results();

    // random commands
    for (int k = 0; k < RAND_ITEMS; k++) begin
      allow_idle = (k < RAND_ITEMS - 100) && !(k >= 150 && k < 200);
      pick = $urandom_range(0, 99);
      val = $urandom;
      if (pick < 35) begin
        // duplicate of a held entry
        op = OP_INSERT;
        if (shadow_count > 0) val = shadow_store[$urandom_range(0, shadow_count - 1)];
      end else if (pick < 60) begin
        op = OP_INSERT;
        case ($urandom_range(0, 5))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = 32'h0000_0000;
          3: val = $urandom_range(0, 31);
          default: ;
        endcase
      end else if (pick < 72) begin
        op = OP_DUMP_FWD;
      end else if (pick < 84) begin
        op = OP_DUMP_REV;
      end else begin
        op = OP_SIZE;
      end
      send_item(op, val, allow_idle);
      if (k % 100 == 50) begin
        start <= 1'b0;
        drain_results();
      end
    end

    // wrap up
    start <= 1'b0;
    drain_results();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
